// ===== hw/rtl/csvfs_pkg.sv =====
// csvfs_pkg: shared types and constants for the csv field splitter
// used by csvfs_ctrl, csvfs_dp and csv_field_splitter; no dependencies
`default_nettype none

package csvfs_pkg;

  // default depth of the held-blank store
  localparam int unsigned MAX_PENDING_DEF = 16;

  // character codes
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_HELD
  } state_e;

  // datapath commands
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_NUL,
    CMD_DELIM,
    CMD_BLANK,
    CMD_CONTENT,
    CMD_HOLD,
    CMD_FLUSH,
    CMD_EMIT
  } cmd_e;

  // datapath status toward the controller
  typedef struct packed {
    logic is_nul;
    logic is_delim;
    logic is_blank;
    logic pend_nz;
    logic out_free;
    logic flush_last;
  } csvfs_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/csvfs_ctrl.sv =====
// csvfs_ctrl: sequencer for the csv field splitter
// depends on csvfs_pkg; drives commands into csvfs_dp
`default_nettype none

module csvfs_ctrl
  import csvfs_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output      logic          in_stall_o,
  input  wire csvfs_status_t status_i,
  output      cmd_e          cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE) || !status_i.out_free;
  assign accept     = in_valid_i && !in_stall_o;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && !status_i.is_nul && !status_i.is_delim &&
            !status_i.is_blank && status_i.pend_nz) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (status_i.out_free && status_i.flush_last) begin
          state_d = ST_HELD;
        end
      end
      ST_HELD: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // command decode
  always_comb begin
    cmd_o = CMD_NONE;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (status_i.is_nul) begin
            cmd_o = CMD_NUL;
          end else if (status_i.is_delim) begin
            cmd_o = CMD_DELIM;
          end else if (status_i.is_blank) begin
            cmd_o = CMD_BLANK;
          end else if (status_i.pend_nz) begin
            cmd_o = CMD_HOLD;
          end else begin
            cmd_o = CMD_CONTENT;
          end
        end
      end
      ST_FLUSH: begin
        if (status_i.out_free) begin
          cmd_o = CMD_FLUSH;
        end
      end
      ST_HELD: begin
        if (status_i.out_free) begin
          cmd_o = CMD_EMIT;
        end
      end
      default: cmd_o = CMD_NONE;
    endcase
  end

  // no new beat is taken while blanks are being released
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o)
    else $error("input taken while busy");

  // a held byte always starts a flush
  a_hold_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o == CMD_HOLD) |=> (state_q == ST_FLUSH))
    else $error("hold without flush");

  // a blocked output keeps the flush in place
  a_flush_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH && !status_i.out_free) |=> (state_q == ST_FLUSH))
    else $error("flush left while output blocked");

endmodule

`default_nettype wire

// ===== hw/rtl/csvfs_dp.sv =====
// csvfs_dp: field state, held-blank store and output register
// depends on csvfs_pkg; commanded by csvfs_ctrl
`default_nettype none

module csvfs_dp
  import csvfs_pkg::*;
#(
  parameter int unsigned MAX_PENDING = MAX_PENDING_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [7:0]    data_byte_i,
  input  wire cmd_e          cmd_i,
  output      csvfs_status_t status_o,
  input  wire logic          out_stall_i,
  output      logic          out_valid_o,
  output      logic [7:0]    out_byte_o,
  output      logic          byte_valid_o,
  output      logic          field_end_o,
  output      logic          record_end_o,
  output      logic          blank_overflow_o,
  output      logic          last_o
);

  localparam int unsigned CNT_W = $clog2(MAX_PENDING + 1);
  localparam int unsigned PTR_W = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;

  // field state
  logic             quote_odd_q, quote_odd_d;
  logic             seen_content_q, seen_content_d;
  logic             seen_any_q, seen_any_d;
  logic             ovf_q, ovf_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [7:0]       held_q;

  // held-blank store, 1 marks a tab
  logic             pend_mem [MAX_PENDING];
  logic             rd_tab_q;
  logic             wr_en;

  // output register
  logic             out_valid_q, out_valid_d;
  logic             load;
  logic [7:0]       ld_byte;
  logic             ld_bvalid, ld_fend, ld_rend, ld_ovf, ld_last;
  logic [7:0]       out_byte_q;
  logic             byte_valid_q, field_end_q, record_end_q, ovf_out_q, last_q;

  logic             is_blank, out_free, flush_last;

  // byte classes and status
  assign is_blank   = (data_byte_i == CHAR_SPACE) || (data_byte_i == CHAR_TAB);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign flush_last = ((CNT_W'(rd_ptr_q) + CNT_W'(1)) == cnt_q);

  assign status_o.is_nul     = (data_byte_i == CHAR_NUL);
  assign status_o.is_delim   = !quote_odd_q &&
                               ((data_byte_i == CHAR_COMMA) || (data_byte_i == CHAR_LF));
  assign status_o.is_blank   = is_blank;
  assign status_o.pend_nz    = (cnt_q != '0);
  assign status_o.out_free   = out_free;
  assign status_o.flush_last = flush_last;

  // state update and result selection
  always_comb begin
    quote_odd_d    = quote_odd_q;
    seen_content_d = seen_content_q;
    seen_any_d     = seen_any_q;
    ovf_d          = ovf_q;
    cnt_d          = cnt_q;
    rd_ptr_d       = rd_ptr_q;
    wr_en          = 1'b0;
    load           = 1'b0;
    ld_byte        = 8'h00;
    ld_bvalid      = 1'b0;
    ld_fend        = 1'b0;
    ld_rend        = 1'b0;
    ld_ovf         = 1'b0;
    ld_last        = 1'b0;
    case (cmd_i)
      CMD_NUL: begin
        load           = 1'b1;
        ld_fend        = seen_any_q;
        ld_rend        = 1'b1;
        ld_ovf         = seen_any_q && ovf_q;
        ld_last        = 1'b1;
        quote_odd_d    = 1'b0;
        seen_content_d = 1'b0;
        seen_any_d     = 1'b0;
        ovf_d          = 1'b0;
        cnt_d          = '0;
      end
      CMD_DELIM: begin
        load           = 1'b1;
        ld_fend        = 1'b1;
        ld_ovf         = ovf_q;
        ld_last        = 1'b1;
        seen_content_d = 1'b0;
        seen_any_d     = 1'b0;
        ovf_d          = 1'b0;
        cnt_d          = '0;
      end
      CMD_BLANK: begin
        seen_any_d = 1'b1;
        if (seen_content_q) begin
          if (cnt_q < CNT_W'(MAX_PENDING)) begin
            wr_en = 1'b1;
            cnt_d = cnt_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
      CMD_CONTENT: begin
        load           = 1'b1;
        ld_byte        = data_byte_i;
        ld_bvalid      = 1'b1;
        ld_last        = 1'b1;
        quote_odd_d    = quote_odd_q ^ (data_byte_i == CHAR_QUOTE);
        seen_any_d     = 1'b1;
        seen_content_d = 1'b1;
      end
      CMD_HOLD: begin
        quote_odd_d    = quote_odd_q ^ (data_byte_i == CHAR_QUOTE);
        seen_any_d     = 1'b1;
        seen_content_d = 1'b1;
        rd_ptr_d       = '0;
      end
      CMD_FLUSH: begin
        load      = 1'b1;
        ld_byte   = rd_tab_q ? CHAR_TAB : CHAR_SPACE;
        ld_bvalid = 1'b1;
        if (!flush_last) begin
          rd_ptr_d = rd_ptr_q + PTR_W'(1);
        end
      end
      CMD_EMIT: begin
        load      = 1'b1;
        ld_byte   = held_q;
        ld_bvalid = 1'b1;
        ld_last   = 1'b1;
        cnt_d     = '0;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_d = load || (out_valid_q && out_stall_i);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quote_odd_q    <= 1'b0;
      seen_content_q <= 1'b0;
      seen_any_q     <= 1'b0;
      ovf_q          <= 1'b0;
      cnt_q          <= '0;
      rd_ptr_q       <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      quote_odd_q    <= quote_odd_d;
      seen_content_q <= seen_content_d;
      seen_any_q     <= seen_any_d;
      ovf_q          <= ovf_d;
      cnt_q          <= cnt_d;
      rd_ptr_q       <= rd_ptr_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // held byte while blanks drain
  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_HOLD) begin
      held_q <= data_byte_i;
    end
  end

  // blank store: write at the fill count, registered read at the next pointer
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pend_mem[cnt_q[PTR_W-1:0]] <= (data_byte_i == CHAR_TAB);
    end
    rd_tab_q <= pend_mem[rd_ptr_d];
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q   <= ld_byte;
      byte_valid_q <= ld_bvalid;
      field_end_q  <= ld_fend;
      record_end_q <= ld_rend;
      ovf_out_q    <= ld_ovf;
      last_q       <= ld_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign byte_valid_o     = byte_valid_q;
  assign field_end_o      = field_end_q;
  assign record_end_o     = record_end_q;
  assign blank_overflow_o = ovf_out_q;
  assign last_o           = last_q;

  // fill count never passes the store depth
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_PENDING))
    else $error("blank count out of range");

  // a flush only runs with blanks held
  a_flush_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_FLUSH) |-> (cnt_q != '0))
    else $error("flush with empty store");

  // overflow is reported only on a field end
  a_ovf_fend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ovf_out_q) |-> (field_end_q && !byte_valid_q))
    else $error("overflow flag off a field end");

endmodule

`default_nettype wire

// ===== hw/rtl/csv_field_splitter.sv =====
// csv_field_splitter: top level, splits a record byte stream into fields
// depends on csvfs_pkg, csvfs_ctrl and csvfs_dp
//
//   channel  direction  handshake             payload
//   in       sink       in_valid_i/in_stall_o  data_byte_i
//   out      source     out_valid_o/out_stall_i out_byte_o, byte_valid_o, field_end_o,
//                                              record_end_o, blank_overflow_o, last_o
//
// a byte with at most one result leaves the sequencer idle; the next beat enters in the
// same cycle as the waiting result is taken
// a content byte behind n held blanks gives one result per cycle while the output is not
// stalled, each blank from the single read port of the blank store, then the byte itself
// reset is asynchronous, active low, and clears all field state; no sweep
// a stall on the output holds a waiting result in the result register and stalls the input
`default_nettype none

module csv_field_splitter
  import csvfs_pkg::*;
#(
  parameter int unsigned MAX_PENDING = MAX_PENDING_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_stall_o,
  input  wire logic [7:0] data_byte_i,
  output      logic       out_valid_o,
  input  wire logic       out_stall_i,
  output      logic [7:0] out_byte_o,
  output      logic       byte_valid_o,
  output      logic       field_end_o,
  output      logic       record_end_o,
  output      logic       blank_overflow_o,
  output      logic       last_o
);

  csvfs_status_t status;
  cmd_e          cmd;

  // sequencer
  csvfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  csvfs_dp #(
    .MAX_PENDING (MAX_PENDING)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .data_byte_i      (data_byte_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .out_byte_o       (out_byte_o),
    .byte_valid_o     (byte_valid_o),
    .field_end_o      (field_end_o),
    .record_end_o     (record_end_o),
    .blank_overflow_o (blank_overflow_o),
    .last_o           (last_o)
  );

endmodule

`default_nettype wire

// ===== verif/tb_csv_field_splitter.sv =====
// tb_csv_field_splitter: self-checking bench for the csv field splitter, a directed
// probe table followed by random records under several idle and stall mixes
// depends on csvfs_pkg and csv_field_splitter
`default_nettype none

module tb_csv_field_splitter
  import csvfs_pkg::*;
();

  localparam int unsigned HELD_MAX   = MAX_PENDING_DEF;
  localparam int unsigned CYCLE_CAP  = 1_000_000;
  localparam int unsigned PHASE_BYTES = 60;
  localparam int unsigned REPORT_MAX = 10;

  // one output beat as the block presents it
  typedef struct packed {
    logic [7:0] ch;
    logic       ch_ok;
    logic       fend;
    logic       rend;
    logic       ovf;
    logic       is_last;
  } result_t;

  // one probe row: byte, repeat count, and a hand-written beat where obvious
  typedef struct packed {
    logic [7:0] b;
    logic [4:0] reps;
    logic       typed;
    result_t    exp;
  } row_t;

  localparam result_t NO_BEAT = '0;

  localparam row_t PROBES [24] = '{
    // record end with nothing before it
    '{CHAR_NUL,   5'd1,  1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1}},
    // empty fields on both delimiters
    '{CHAR_COMMA, 5'd1,  1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1}},
    '{CHAR_LF,    5'd1,  1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1}},
    // leading blanks are dropped
    '{CHAR_SPACE, 5'd2,  1'b0, NO_BEAT},
    '{CHAR_TAB,   5'd1,  1'b0, NO_BEAT},
    '{8'h41,      5'd1,  1'b1, '{8'h41, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1}},
    // inner blanks held, then released ahead of content
    '{CHAR_SPACE, 5'd1,  1'b0, NO_BEAT},
    '{CHAR_TAB,   5'd1,  1'b0, NO_BEAT},
    '{8'h42,      5'd1,  1'b0, NO_BEAT},
    // delimiters inside quotes are data
    '{CHAR_QUOTE, 5'd1,  1'b1, '{CHAR_QUOTE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{CHAR_COMMA, 5'd1,  1'b1, '{CHAR_COMMA, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{CHAR_LF,    5'd1,  1'b1, '{CHAR_LF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{CHAR_SPACE, 5'd1,  1'b0, NO_BEAT},
    '{CHAR_QUOTE, 5'd1,  1'b0, NO_BEAT},
    // byte extremes
    '{8'hFF,      5'd1,  1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{8'h01,      5'd1,  1'b1, '{8'h01, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1}},
    // overfill the blank store, then release a full store
    '{CHAR_SPACE, 5'd20, 1'b0, NO_BEAT},
    '{8'h43,      5'd1,  1'b0, NO_BEAT},
    // field end carries the dropped-blank flag
    '{CHAR_COMMA, 5'd1,  1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1}},
    // blanks-only field still closes as a field
    '{CHAR_SPACE, 5'd1,  1'b0, NO_BEAT},
    '{CHAR_NUL,   5'd1,  1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1}},
    // record end inside open quotes, parity must clear
    '{CHAR_QUOTE, 5'd1,  1'b1, '{CHAR_QUOTE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{CHAR_NUL,   5'd1,  1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1}},
    '{CHAR_COMMA, 5'd1,  1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1}}
  };

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] data_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic       field_end_o;
  logic       record_end_o;
  logic       blank_overflow_o;
  logic       last_o;

  csv_field_splitter DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .byte_valid_o    (byte_valid_o),
    .field_end_o     (field_end_o),
    .record_end_o    (record_end_o),
    .blank_overflow_o(blank_overflow_o),
    .last_o          (last_o)
  );

  // splitter state mirrored by the predictor
  logic           in_quotes;
  logic           have_content;
  logic           have_bytes;
  int unsigned    held_cnt;
  logic           held_tab [HELD_MAX];
  logic           dropped_blank;

  result_t        split_beats [$];
  result_t        due_beats [$];
  int unsigned    snd_idle_pct = 0;
  int unsigned    rcv_idle_pct = 0;
  int unsigned    hold_left = 0;
  int unsigned    cycle_cnt = 0;
  int unsigned    bytes_sent = 0;
  int unsigned    records_sent = 0;
  int unsigned    beats_seen = 0;
  int unsigned    mismatches = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    while (cycle_cnt < CYCLE_CAP) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb_csv_field_splitter: errors");
    $finish;
  end

  // predicted beats for one accepted record byte, left in split_beats
  task automatic split_byte(input logic [7:0] b);
    result_t r;
    split_beats.delete();
    if (b == CHAR_NUL) begin
      r = NO_BEAT;
      r.rend = 1'b1;
      if (have_bytes) begin
        r.fend = 1'b1;
        r.ovf  = dropped_blank;
      end
      split_beats = {split_beats, r};
      in_quotes     = 1'b0;
      have_content  = 1'b0;
      have_bytes    = 1'b0;
      held_cnt      = 0;
      dropped_blank = 1'b0;
    end else if (!in_quotes && (b == CHAR_COMMA || b == CHAR_LF)) begin
      r = NO_BEAT;
      r.fend = 1'b1;
      r.ovf  = dropped_blank;
      split_beats = {split_beats, r};
      have_content  = 1'b0;
      have_bytes    = 1'b0;
      held_cnt      = 0;
      dropped_blank = 1'b0;
    end else begin
      have_bytes = 1'b1;
      if (b == CHAR_SPACE || b == CHAR_TAB) begin
        // leading blanks vanish, inner ones wait for more content
        if (have_content) begin
          if (held_cnt < HELD_MAX) begin
            held_tab[held_cnt] = (b == CHAR_TAB);
            held_cnt++;
          end else begin
            dropped_blank = 1'b1;
          end
        end
      end else begin
        if (b == CHAR_QUOTE) in_quotes = ~in_quotes;
        for (int i = 0; i < held_cnt; i++) begin
          r = NO_BEAT;
          r.ch    = held_tab[i] ? CHAR_TAB : CHAR_SPACE;
          r.ch_ok = 1'b1;
          split_beats = {split_beats, r};
        end
        held_cnt = 0;
        r = NO_BEAT;
        r.ch    = b;
        r.ch_ok = 1'b1;
        split_beats = {split_beats, r};
        have_content = 1'b1;
      end
    end
    if (split_beats.size() > 0) begin
      split_beats[split_beats.size() - 1].is_last = 1'b1;
    end
  endtask

  // offer one byte, wait for its beat to be taken, queue what it should produce
  task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                           input result_t exp = NO_BEAT);
    while (snd_idle_pct != 0 && $urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    split_byte(b);
    if (typed) due_beats = {due_beats, exp};
    else due_beats = {due_beats, split_beats};
    bytes_sent++;
  endtask

  function automatic logic [7:0] any_blank();
    return ($urandom_range(0, 1) != 0) ? CHAR_TAB : CHAR_SPACE;
  endfunction

  // mostly plain text, now and then any nonzero byte at all
  function automatic logic [7:0] any_content();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'($urandom_range(1, 255));
    if (r < 25) return 8'($urandom_range(8'h30, 8'h39));
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  // one well-formed record with random field content
  task automatic send_record();
    int unsigned nfields;
    int unsigned nparts;
    int unsigned r;
    nfields = $urandom_range(1, 4);
    for (int f = 0; f < nfields; f++) begin
      repeat ($urandom_range(0, 2)) send_byte(any_blank());
      nparts = $urandom_range(0, 5);
      for (int p = 0; p < nparts; p++) begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          repeat ($urandom_range(1, 3)) send_byte(any_blank());
        end else if (r < 16) begin
          // long blank run, from just under the store depth to past it
          repeat ($urandom_range(HELD_MAX - 1, HELD_MAX + 3)) send_byte(any_blank());
        end else if (r < 26) begin
          // quoted section holding delimiters and blanks
          send_byte(CHAR_QUOTE);
          repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 3))
              0:       send_byte(CHAR_COMMA);
              1:       send_byte(CHAR_LF);
              2:       send_byte(any_blank());
              default: send_byte(any_content());
            endcase
          end
          send_byte(CHAR_QUOTE);
        end else begin
          send_byte(any_content());
        end
      end
      repeat ($urandom_range(0, 2)) send_byte(any_blank());
      if (f + 1 < nfields) send_byte(($urandom_range(0, 1) != 0) ? CHAR_COMMA : CHAR_LF);
    end
    send_byte(CHAR_NUL);
    records_sent++;
  endtask

  // output side: random stall, or a long hold-off when asked
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= (rcv_idle_pct != 0) && ($urandom_range(0, 99) < rcv_idle_pct);
      end
    end
  end

  // compare every taken output beat with the oldest one due
  always @(posedge clk_i) begin
    result_t got;
    result_t exp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{out_byte_o, byte_valid_o, field_end_o, record_end_o, blank_overflow_o, last_o};
      beats_seen++;
      if (due_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("beat %0d not due: byte %02h valid %b fend %b rend %b ovf %b last %b",
                   beats_seen, got.ch, got.ch_ok, got.fend, got.rend, got.ovf, got.is_last);
      end else begin
        exp = due_beats.pop_front();
        if (got !== exp) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("beat %0d: exp byte %02h valid %b fend %b rend %b ovf %b last %b, %s",
                     beats_seen, exp.ch, exp.ch_ok, exp.fend, exp.rend, exp.ovf, exp.is_last,
                     $sformatf("got byte %02h valid %b fend %b rend %b ovf %b last %b",
                               got.ch, got.ch_ok, got.fend, got.rend, got.ovf, got.is_last));
        end
      end
    end
  end

  // main sequence
  initial begin
    int unsigned phase_end;
    in_quotes     = 1'b0;
    have_content  = 1'b0;
    have_bytes    = 1'b0;
    held_cnt      = 0;
    dropped_blank = 1'b0;
    foreach (held_tab[i]) held_tab[i] = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed probes
    for (int i = 0; i < $size(PROBES); i++)
      repeat (PROBES[i].reps) send_byte(PROBES[i].b, PROBES[i].typed, PROBES[i].exp);

    // long output hold-off while records keep coming
    hold_left = 240;
    repeat (4) send_record();

    // random records under each idle mix
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
        1:       begin snd_idle_pct = 66; rcv_idle_pct = 0;  end
        2:       begin snd_idle_pct = 0;  rcv_idle_pct = 66; end
        default: begin snd_idle_pct = 29; rcv_idle_pct = 29; end
      endcase
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) begin
        if ($urandom_range(0, 99) < 12) begin
          // noise: arbitrary bytes, NUL included
          repeat ($urandom_range(1, 10)) send_byte(8'($urandom_range(0, 255)));
        end else begin
          send_record();
        end
      end
    end

    // drain and settle
    in_valid_i   <= 1'b0;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    while (due_beats.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    mismatches += due_beats.size();

    $display("sent %0d record bytes in %0d random records after %0d probe rows",
             bytes_sent, records_sent, $size(PROBES));
    $display("checked %0d output beats over four idle mixes and one long output hold-off",
             beats_seen);
    if (mismatches == 0) begin
      $display("tb_csv_field_splitter: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_csv_field_splitter: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
